// ----- hw/rtl/dcr_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dcr_pkg: shared types and constants of the distance constraint relaxer
// Field widths, internal datapath widths and the per-stage item records.
// ----------------------------------------------------------------------------
package dcr_pkg;

  localparam int CoordW    = 16;
  localparam int DiffW     = 17;
  localparam int SqW       = 34;
  localparam int RadW      = 50;  // squared distance with guard fraction bits
  localparam int RootW     = 25;
  localparam int RemW      = 28;
  localparam int RestW     = 15;
  localparam int GuardBits = 8;
  localparam int LenDiffW  = 26;  // signed rest minus distance
  localparam int NumW      = 43;
  localparam int DivW      = 44;
  localparam int DenW      = 26;
  localparam int QuoW      = 18;
  localparam int SqrtSteps = RadW / 2;
  localparam int DivSteps  = QuoW;

  localparam logic [RestW-1:0] RestReset = 15'd160;

  // Item data carried alongside the arithmetic
  typedef struct packed {
    logic signed [CoordW-1:0] x1;
    logic signed [CoordW-1:0] y1;
    logic signed [CoordW-1:0] x2;
    logic signed [CoordW-1:0] y2;
    logic                     pin1;
    logic                     pin2;
    logic                     act;
    logic                     zero;
    logic signed [DiffW-1:0]  dx;
    logic signed [DiffW-1:0]  dy;
  } side_t;

  typedef struct packed {
    logic [RadW-1:0]  rad;
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
    side_t            side;
  } sqrt_t;

  typedef struct packed {
    logic [DivW-1:0] remx;
    logic [DivW-1:0] remy;
    logic [QuoW-1:0] qx;
    logic [QuoW-1:0] qy;
    logic [DenW-1:0] den;
    logic            negx;
    logic            negy;
    side_t           side;
  } div_t;

  // Clamp a 20-bit signed sum to the coordinate range
  function automatic logic signed [CoordW-1:0] sat16(input logic signed [19:0] v);
    logic signed [CoordW-1:0] r;
    if (v > 20'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -20'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[CoordW-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/dcr_sqrt_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dcr_sqrt_cell: one digit of the square root chain
// Retires two radicand bits and one root bit, then hands the item on.
// ----------------------------------------------------------------------------
module dcr_sqrt_cell (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  input  wire dcr_pkg::sqrt_t data_i,
  output logic                valid_o,
  output dcr_pkg::sqrt_t      data_o
);

  logic [dcr_pkg::RemW-1:0] rem_sh;
  logic [dcr_pkg::RemW-1:0] trial;
  logic                     ge;
  dcr_pkg::sqrt_t           data_d;

  // restoring step: try (4*root + 1) against the shifted remainder
  always_comb begin
    rem_sh = {data_i.rem[dcr_pkg::RemW-3:0], data_i.rad[dcr_pkg::RadW-1 -: 2]};
    trial  = {1'b0, data_i.root, 2'b01};
    ge     = (rem_sh >= trial);
    data_d      = data_i;
    data_d.rad  = data_i.rad << 2;
    data_d.rem  = ge ? (rem_sh - trial) : rem_sh;
    data_d.root = {data_i.root[dcr_pkg::RootW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_o <= data_d;
  end

endmodule
`default_nettype wire

// ----- hw/rtl/dcr_div_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dcr_div_cell: one quotient bit of the x and y offset dividers
// Compares both partial remainders against the shifted divisor.
// ----------------------------------------------------------------------------
module dcr_div_cell #(
  parameter int Shift = 0
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  input  wire dcr_pkg::div_t data_i,
  output logic               valid_o,
  output dcr_pkg::div_t      data_o
);

  logic [dcr_pkg::DivW-1:0] cmp;
  logic                     gex;
  logic                     gey;
  dcr_pkg::div_t            data_d;

  // restoring step at quotient bit Shift for both lanes
  always_comb begin
    cmp    = dcr_pkg::DivW'(data_i.den) << Shift;
    gex    = (data_i.remx >= cmp);
    gey    = (data_i.remy >= cmp);
    data_d = data_i;
    data_d.remx      = gex ? (data_i.remx - cmp) : data_i.remx;
    data_d.remy      = gey ? (data_i.remy - cmp) : data_i.remy;
    data_d.qx[Shift] = gex;
    data_d.qy[Shift] = gey;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_o <= data_d;
  end

endmodule
`default_nettype wire

// ----- hw/rtl/distance_constraint_relax.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// distance_constraint_relax: one Verlet rod relaxation per item
// Moves two points toward the configured rest length, Q12.4, saturated.
// ----------------------------------------------------------------------------
// Usage:
//   An item (two points, pin flags, active flag) is taken at a clock edge
//   with start high and busy low. busy is always low: the datapath is a
//   pipeline that takes one item every cycle.
//   Each result appears on the new_* ports and zero_distance_o for one
//   cycle with result_valid_o high, once its item has passed the chain
//   of cells: 3 front stages (difference, squares, sum), 25 square root
//   cells, 2 stages for the product and the dividend, 18 divider cells
//   and the output register.
//   Results leave in item order; the receiver cannot stall.
//   rest_length is written over cfg_valid_i/cfg_ready_o (ready always high)
//   and must only change while no item is in flight.
//   Reset empties the pipeline and sets rest_length to 10.0 (160).
// ----------------------------------------------------------------------------
module distance_constraint_relax (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic signed [dcr_pkg::CoordW-1:0] first_x_i,
  input  wire logic signed [dcr_pkg::CoordW-1:0] first_y_i,
  input  wire logic signed [dcr_pkg::CoordW-1:0] second_x_i,
  input  wire logic signed [dcr_pkg::CoordW-1:0] second_y_i,
  input  wire logic                            first_pinned_i,
  input  wire logic                            second_pinned_i,
  input  wire logic                            rod_active_i,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [dcr_pkg::RestW-1:0]       cfg_data_i,
  output logic                                 result_valid_o,
  output logic signed [dcr_pkg::CoordW-1:0]    new_first_x_o,
  output logic signed [dcr_pkg::CoordW-1:0]    new_first_y_o,
  output logic signed [dcr_pkg::CoordW-1:0]    new_second_x_o,
  output logic signed [dcr_pkg::CoordW-1:0]    new_second_y_o,
  output logic                                 zero_distance_o
);

  localparam int Lat = 3 + dcr_pkg::SqrtSteps + 2 + dcr_pkg::DivSteps + 1;

  logic                      accept;
  logic [dcr_pkg::RestW-1:0] rest_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  // rest length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rest_q <= dcr_pkg::RestReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      rest_q <= cfg_data_i;
    end
  end

  // stage 0: capture item, form differences
  logic          s0_valid_q;
  dcr_pkg::side_t s0_q, s0_d;

  always_comb begin
    s0_d      = '0;
    s0_d.x1   = first_x_i;
    s0_d.y1   = first_y_i;
    s0_d.x2   = second_x_i;
    s0_d.y2   = second_y_i;
    s0_d.pin1 = first_pinned_i;
    s0_d.pin2 = second_pinned_i;
    s0_d.act  = rod_active_i;
    s0_d.dx   = dcr_pkg::DiffW'(first_x_i) - dcr_pkg::DiffW'(second_x_i);
    s0_d.dy   = dcr_pkg::DiffW'(first_y_i) - dcr_pkg::DiffW'(second_y_i);
  end

  // stage 1: squares
  logic                              s1_valid_q;
  dcr_pkg::side_t                    s1_q;
  logic signed [dcr_pkg::SqW-1:0]    xx_d, yy_d;
  logic [dcr_pkg::SqW-1:0]           xx_q, yy_q;

  assign xx_d = s0_q.dx * s0_q.dx;
  assign yy_d = s0_q.dy * s0_q.dy;

  // stage 2: sum of squares, coincidence check, sqrt chain entry
  logic              s2_valid_q;
  dcr_pkg::sqrt_t    s2_q, s2_d;
  logic [dcr_pkg::SqW-1:0] d2;

  always_comb begin
    d2             = xx_q + yy_q;
    s2_d.rad       = {d2, {(2 * dcr_pkg::GuardBits){1'b0}}};
    s2_d.rem       = '0;
    s2_d.root      = '0;
    s2_d.side      = s1_q;
    s2_d.side.zero = s1_q.act && (d2 == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s0_valid_q <= accept;
      s1_valid_q <= s0_valid_q;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_q <= s0_d;
    s1_q <= s0_q;
    xx_q <= xx_d;
    yy_q <= yy_d;
    s2_q <= s2_d;
  end

  // square root chain
  logic           sq_valid [dcr_pkg::SqrtSteps+1];
  dcr_pkg::sqrt_t sq_data  [dcr_pkg::SqrtSteps+1];

  assign sq_valid[0] = s2_valid_q;
  assign sq_data[0]  = s2_q;

  for (genvar i = 0; i < dcr_pkg::SqrtSteps; i++) begin : g_sqrt
    dcr_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (sq_valid[i]),
      .data_i  (sq_data[i]),
      .valid_o (sq_valid[i+1]),
      .data_o  (sq_data[i+1])
    );
  end

  // stage M: offset numerators d * (Lg - Dg)
  dcr_pkg::sqrt_t                  sq_out;
  logic signed [dcr_pkg::LenDiffW-1:0] len_diff;
  logic signed [dcr_pkg::NumW-1:0] numx_d, numy_d, numx_q, numy_q;
  logic [dcr_pkg::RootW-1:0]       dg_q;
  dcr_pkg::side_t                  sm_q;
  logic                            sm_valid_q;

  assign sq_out   = sq_data[dcr_pkg::SqrtSteps];
  assign len_diff = $signed({3'b0, rest_q, {dcr_pkg::GuardBits{1'b0}}})
                  - $signed({1'b0, sq_out.root});
  assign numx_d   = sq_out.side.dx * len_diff;
  assign numy_d   = sq_out.side.dy * len_diff;

  // stage N: magnitudes plus rounding term, divider entry
  logic                        sn_valid_q;
  dcr_pkg::div_t               sn_q, sn_d;
  logic [dcr_pkg::NumW-1:0]    magx, magy;

  always_comb begin
    magx      = numx_q[dcr_pkg::NumW-1] ? dcr_pkg::NumW'(-numx_q) : dcr_pkg::NumW'(numx_q);
    magy      = numy_q[dcr_pkg::NumW-1] ? dcr_pkg::NumW'(-numy_q) : dcr_pkg::NumW'(numy_q);
    sn_d.remx = {1'b0, magx} + dcr_pkg::DivW'(dg_q);
    sn_d.remy = {1'b0, magy} + dcr_pkg::DivW'(dg_q);
    sn_d.qx   = '0;
    sn_d.qy   = '0;
    sn_d.den  = {dg_q, 1'b0};
    sn_d.negx = numx_q[dcr_pkg::NumW-1];
    sn_d.negy = numy_q[dcr_pkg::NumW-1];
    sn_d.side = sm_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sm_valid_q <= 1'b0;
      sn_valid_q <= 1'b0;
    end else begin
      sm_valid_q <= sq_valid[dcr_pkg::SqrtSteps];
      sn_valid_q <= sm_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    numx_q <= numx_d;
    numy_q <= numy_d;
    dg_q   <= sq_out.root;
    sm_q   <= sq_out.side;
    sn_q   <= sn_d;
  end

  // divider chain, most significant quotient bit first
  logic          dv_valid [dcr_pkg::DivSteps+1];
  dcr_pkg::div_t dv_data  [dcr_pkg::DivSteps+1];

  assign dv_valid[0] = sn_valid_q;
  assign dv_data[0]  = sn_q;

  for (genvar i = 0; i < dcr_pkg::DivSteps; i++) begin : g_div
    dcr_div_cell #(
      .Shift (dcr_pkg::DivSteps - 1 - i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (dv_valid[i]),
      .data_i  (dv_data[i]),
      .valid_o (dv_valid[i+1]),
      .data_o  (dv_data[i+1])
    );
  end

  // output stage: apply offsets, saturate
  dcr_pkg::div_t      dv_out;
  logic signed [18:0] ox, oy;
  logic               move;
  logic signed [dcr_pkg::CoordW-1:0] n1x_d, n1y_d, n2x_d, n2y_d;

  assign dv_out = dv_data[dcr_pkg::DivSteps];

  always_comb begin
    ox   = dv_out.negx ? -$signed({1'b0, dv_out.qx}) : $signed({1'b0, dv_out.qx});
    oy   = dv_out.negy ? -$signed({1'b0, dv_out.qy}) : $signed({1'b0, dv_out.qy});
    move = dv_out.side.act && !dv_out.side.zero;
    n1x_d = dv_out.side.x1;
    n1y_d = dv_out.side.y1;
    n2x_d = dv_out.side.x2;
    n2y_d = dv_out.side.y2;
    if (move && !dv_out.side.pin1) begin
      n1x_d = dcr_pkg::sat16(20'(dv_out.side.x1) + 20'(ox));
      n1y_d = dcr_pkg::sat16(20'(dv_out.side.y1) + 20'(oy));
    end
    if (move && !dv_out.side.pin2) begin
      n2x_d = dcr_pkg::sat16(20'(dv_out.side.x2) - 20'(ox));
      n2y_d = dcr_pkg::sat16(20'(dv_out.side.y2) - 20'(oy));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o  <= 1'b0;
      zero_distance_o <= 1'b0;
    end else begin
      result_valid_o  <= dv_valid[dcr_pkg::DivSteps];
      zero_distance_o <= dv_valid[dcr_pkg::DivSteps] && dv_out.side.zero;
    end
  end

  always_ff @(posedge clk_i) begin
    new_first_x_o  <= n1x_d;
    new_first_y_o  <= n1y_d;
    new_second_x_o <= n2x_d;
    new_second_y_o <= n2y_d;
  end

  // each result strobe follows an accepted item through the whole pipeline
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o == $past(start && !busy, Lat))
    else $error("result strobe out of step with accepted items");

  // coincidence flag only rides on a result
  a_zero_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    zero_distance_o |-> result_valid_o)
    else $error("zero_distance without result");

  // coincident points leave the first point in place
  a_zero_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    zero_distance_o |-> (new_first_x_o == $past(first_x_i, Lat))
                        && (new_first_y_o == $past(first_y_i, Lat)))
    else $error("coincident points moved");

endmodule
`default_nettype wire
